// ===== rtl/socs_pkg.sv =====
// Shared types and constants for the second-order consensus step core.
// No dependencies.
package socs_pkg;

    localparam int AGENT_COUNT = 8;
    localparam int AGENT_W = 3;
    localparam int VAL_W = 32;
    localparam int DT_W = 24;
    localparam int GAIN_W = 8;

    localparam logic [2:0] CFG_LEADER = 3'd0;
    localparam logic [2:0] CFG_ALPHA = 3'd1;
    localparam logic [2:0] CFG_BETA = 3'd2;
    localparam logic [2:0] CFG_FOLLOW_EN = 3'd3;
    localparam logic [2:0] CFG_FOLLOW_AGENT = 3'd4;

    localparam logic CMD_LOAD = 1'b0;
    localparam logic CMD_STEP = 1'b1;

    typedef struct packed {
        logic signed [VAL_W-1:0] px;
        logic signed [VAL_W-1:0] py;
        logic signed [VAL_W-1:0] vx;
        logic signed [VAL_W-1:0] vy;
        logic signed [VAL_W-1:0] ux;
        logic signed [VAL_W-1:0] uy;
    } agent_state_t;

    function automatic logic signed [VAL_W-1:0] sat32(input logic signed [63:0] x);
        logic signed [63:0] hi;
        logic signed [63:0] lo;
        hi = 64'sd2147483647;
        lo = -64'sd2147483648;
        if (x > hi) begin
            sat32 = hi[VAL_W-1:0];
        end else if (x < lo) begin
            sat32 = lo[VAL_W-1:0];
        end else begin
            sat32 = x[VAL_W-1:0];
        end
    endfunction

endpackage

// ===== rtl/second_order_consensus_step_core.sv =====
// Second-order consensus step core: agent state in one synchronous memory,
// a shared multiply-accumulate and an Euler update sequencer.
// A load is written at its transfer; the next item can follow in the next cycle.
// A step runs, per agent, a self read, a read and a multiply-accumulate per leader
// candidate, a follow step and a rounding step, then per agent a read, a capture,
// the Euler updates and an output that waits on m_tready. Reset is synchronous,
// active low; a clearing pass zeroes the state memory, taking no item meanwhile.
module second_order_consensus_step_core (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic [2:0]   cfg_index,
    input  logic [63:0]  cfg_data,
    input  logic         s_tvalid,
    output logic         s_tready,
    // tdata: agent_index, pos_x_in, pos_y_in, vel_x_in, vel_y_in, step_length, pad
    input  logic [159:0] s_tdata,
    // tuser: cmd
    input  logic         s_tuser,
    output logic         m_tvalid,
    input  logic         m_tready,
    // tdata: agent_out, pos_x_out, pos_y_out, vel_x_out, vel_y_out, ctl_x_out,
    // ctl_y_out, pad
    output logic [199:0] m_tdata,
    output logic         m_tlast
);

    localparam int AW = socs_pkg::AGENT_W;
    localparam int VW = socs_pkg::VAL_W;

    localparam logic [3:0] ST_CLEAR = 4'd0;
    localparam logic [3:0] ST_IDLE = 4'd1;
    localparam logic [3:0] ST_RDI = 4'd2;
    localparam logic [3:0] ST_RDJ = 4'd3;
    localparam logic [3:0] ST_MAC = 4'd4;
    localparam logic [3:0] ST_CTL = 4'd5;
    localparam logic [3:0] ST_ERD = 4'd6;
    localparam logic [3:0] ST_EMUL = 4'd7;
    localparam logic [3:0] ST_EOUT = 4'd8;
    localparam logic [3:0] ST_WAIT = 4'd9;
    localparam logic [3:0] ST_FOLLOW = 4'd10;

    socs_pkg::agent_state_t mem [socs_pkg::AGENT_COUNT];
    socs_pkg::agent_state_t rd_data;
    logic [AW-1:0] rd_addr;
    logic rd_en;
    logic wr_en;
    logic [AW-1:0] wr_addr;
    socs_pkg::agent_state_t wr_data;

    // Control values of a step are held aside until every agent has used the old ones.
    logic signed [VW-1:0] ux_new_reg [socs_pkg::AGENT_COUNT];
    logic signed [VW-1:0] uy_new_reg [socs_pkg::AGENT_COUNT];

    logic [63:0] leader_reg, alpha_reg, beta_reg;
    logic follow_en_reg;
    logic [AW-1:0] follow_agent_reg;

    logic [3:0] state_reg;
    logic [AW-1:0] i_reg, j_reg;
    socs_pkg::agent_state_t self_reg;
    logic signed [VW-1:0] tx_reg, ty_reg;
    logic [socs_pkg::DT_W-1:0] dt_reg;
    logic signed [63:0] sx_reg, sy_reg;
    logic [1:0] eph_reg;
    logic signed [VW-1:0] res_reg [4];
    logic m_valid_reg;
    logic [199:0] m_data_reg;
    logic m_last_reg;

    logic signed [8:0] al, be;
    logic signed [33:0] dpx, dpy, dvx, dvy;
    logic signed [42:0] pax, pay, pbx, pby;
    logic signed [63:0] sxr, syr, ep;
    logic signed [VW-1:0] e_old, e_rate;

    assign al = $signed({1'b0, alpha_reg[i_reg*8 +: 8]});
    assign be = $signed({1'b0, beta_reg[i_reg*8 +: 8]});

    assign cfg_ready = (state_reg == ST_IDLE);
    assign s_tready = (state_reg == ST_IDLE) && !cfg_valid;
    assign m_tvalid = m_valid_reg;
    assign m_tdata = m_data_reg;
    assign m_tlast = m_last_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

    always_comb begin
        rd_en = 1'b0;
        rd_addr = i_reg;
        unique case (state_reg)
            ST_RDI, ST_ERD: rd_en = 1'b1;
            ST_RDJ: begin
                rd_en = 1'b1;
                rd_addr = j_reg;
            end
            default: rd_en = 1'b0;
        endcase
    end

    always_comb begin
        if (state_reg == ST_FOLLOW) begin
            dpx = 34'(tx_reg) - 34'(self_reg.px);
            dpy = 34'(ty_reg) - 34'(self_reg.py);
            dvx = -34'(self_reg.vx);
            dvy = -34'(self_reg.vy);
        end else begin
            dpx = 34'(rd_data.px) - 34'(self_reg.px);
            dpy = 34'(rd_data.py) - 34'(self_reg.py);
            dvx = 34'(rd_data.vx) - 34'(self_reg.vx);
            dvy = 34'(rd_data.vy) - 34'(self_reg.vy);
        end
        pax = al * dpx;
        pay = al * dpy;
        pbx = be * dvx;
        pby = be * dvy;
        sxr = sx_reg + 64'sd16;
        syr = sy_reg + 64'sd16;
        unique case (eph_reg)
            2'd0: begin
                e_old = self_reg.vx;
                e_rate = self_reg.ux;
            end
            2'd1: begin
                e_old = self_reg.vy;
                e_rate = self_reg.uy;
            end
            2'd2: begin
                e_old = self_reg.px;
                e_rate = self_reg.vx;
            end
            default: begin
                e_old = self_reg.py;
                e_rate = self_reg.vy;
            end
        endcase
        ep = 64'(e_old) + (($signed({40'd0, dt_reg}) * 64'(e_rate)
            + 64'sd8388608) >>> 24);
    end

    always_comb begin
        wr_en = 1'b0;
        wr_addr = i_reg;
        wr_data = '0;
        if (state_reg == ST_CLEAR) begin
            wr_en = 1'b1;
        end else if (state_reg == ST_IDLE && s_tvalid && s_tready && s_tuser == socs_pkg::CMD_LOAD) begin
            wr_en = 1'b1;
            wr_addr = s_tdata[AW-1:0];
            wr_data.px = s_tdata[AW +: VW];
            wr_data.py = s_tdata[AW+VW +: VW];
            wr_data.vx = s_tdata[AW+2*VW +: VW];
            wr_data.vy = s_tdata[AW+3*VW +: VW];
        end else if (state_reg == ST_EOUT) begin
            wr_en = 1'b1;
            wr_data.vx = res_reg[0];
            wr_data.vy = res_reg[1];
            wr_data.px = res_reg[2];
            wr_data.py = res_reg[3];
            wr_data.ux = ux_new_reg[i_reg];
            wr_data.uy = uy_new_reg[i_reg];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_CLEAR;
            i_reg <= '0;
            j_reg <= '0;
            m_valid_reg <= 1'b0;
            leader_reg <= '0;
            alpha_reg <= '0;
            beta_reg <= '0;
            follow_en_reg <= 1'b0;
            follow_agent_reg <= '0;
            eph_reg <= '0;
        end else begin
            if (m_valid_reg && m_tready && state_reg != ST_EOUT) begin
                m_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_CLEAR: begin
                    if (i_reg == AW'(socs_pkg::AGENT_COUNT - 1)) begin
                        state_reg <= ST_IDLE;
                        i_reg <= '0;
                    end else begin
                        i_reg <= i_reg + 1'b1;
                    end
                end
                ST_IDLE: begin
                    if (cfg_valid) begin
                        unique case (cfg_index)
                            socs_pkg::CFG_LEADER: leader_reg <= cfg_data;
                            socs_pkg::CFG_ALPHA: alpha_reg <= cfg_data;
                            socs_pkg::CFG_BETA: beta_reg <= cfg_data;
                            socs_pkg::CFG_FOLLOW_EN: follow_en_reg <= cfg_data[0];
                            socs_pkg::CFG_FOLLOW_AGENT: follow_agent_reg <= cfg_data[AW-1:0];
                            default: ;
                        endcase
                    end else if (s_tvalid && s_tuser == socs_pkg::CMD_STEP) begin
                        tx_reg <= s_tdata[AW +: VW];
                        ty_reg <= s_tdata[AW+VW +: VW];
                        dt_reg <= s_tdata[AW+4*VW +: socs_pkg::DT_W];
                        i_reg <= '0;
                        state_reg <= ST_RDI;
                    end
                end
                ST_RDI: begin
                    j_reg <= '0;
                    sx_reg <= '0;
                    sy_reg <= '0;
                    state_reg <= ST_RDJ;
                end
                ST_RDJ: begin
                    if (j_reg == '0) begin
                        self_reg <= rd_data;
                    end
                    state_reg <= ST_MAC;
                end
                ST_MAC: begin
                    if (leader_reg[{i_reg, j_reg}]) begin
                        sx_reg <= sx_reg + 64'(pax) + 64'(pbx);
                        sy_reg <= sy_reg + 64'(pay) + 64'(pby);
                    end
                    j_reg <= j_reg + 1'b1;
                    if (j_reg == AW'(socs_pkg::AGENT_COUNT - 1)) begin
                        state_reg <= ST_FOLLOW;
                    end else begin
                        state_reg <= ST_RDJ;
                    end
                end
                ST_FOLLOW: begin
                    if (follow_en_reg && follow_agent_reg == i_reg) begin
                        sx_reg <= sx_reg + 64'(pax) + 64'(pbx);
                        sy_reg <= sy_reg + 64'(pay) + 64'(pby);
                    end
                    state_reg <= ST_CTL;
                end
                ST_CTL: begin
                    ux_new_reg[i_reg] <= socs_pkg::sat32(sxr >>> 5);
                    uy_new_reg[i_reg] <= socs_pkg::sat32(syr >>> 5);
                    if (i_reg == AW'(socs_pkg::AGENT_COUNT - 1)) begin
                        i_reg <= '0;
                        state_reg <= ST_ERD;
                    end else begin
                        i_reg <= i_reg + 1'b1;
                        state_reg <= ST_RDI;
                    end
                end
                ST_ERD: begin
                    eph_reg <= '0;
                    state_reg <= ST_EMUL;
                end
                ST_EMUL: begin
                    self_reg <= rd_data;
                    state_reg <= ST_WAIT;
                end
                ST_WAIT: begin
                    res_reg[eph_reg] <= socs_pkg::sat32(ep);
                    eph_reg <= eph_reg + 1'b1;
                    if (eph_reg == 2'd3) begin
                        state_reg <= ST_EOUT;
                    end
                end
                ST_EOUT: begin
                    if (!m_valid_reg || m_tready) begin
                        m_valid_reg <= 1'b1;
                        m_last_reg <= (i_reg == AW'(socs_pkg::AGENT_COUNT - 1));
                        m_data_reg <= {5'd0, uy_new_reg[i_reg], ux_new_reg[i_reg],
                            res_reg[1], res_reg[0], res_reg[3], res_reg[2], i_reg};
                        if (i_reg == AW'(socs_pkg::AGENT_COUNT - 1)) begin
                            i_reg <= '0;
                            state_reg <= ST_IDLE;
                        end else begin
                            i_reg <= i_reg + 1'b1;
                            state_reg <= ST_ERD;
                        end
                    end else begin
                        state_reg <= ST_EOUT;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

endmodule

// ===== rtl/socs_checker.sv =====
// Port-level checker for the consensus step core, bound to the top level.
// Depends on second_order_consensus_step_core ports only.
module socs_checker (
    input logic         aclk,
    input logic         aresetn,
    input logic         s_tready,
    input logic         m_tvalid,
    input logic         m_tready,
    input logic         m_tlast,
    input logic [199:0] m_tdata
);

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    a_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tlast == (m_tdata[2:0] == 3'd7)))
        else $error("last flag does not match agent index");

    a_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tready |-> !m_tvalid || m_tlast)
        else $error("input offered while a step is still reporting");

    a_known: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !$isunknown({m_tdata, m_tlast}))
        else $error("result transfer carries unknown bits");

endmodule

bind second_order_consensus_step_core socs_checker u_socs_checker (
    .aclk(aclk), .aresetn(aresetn), .s_tready(s_tready),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tlast(m_tlast), .m_tdata(m_tdata)
);

// ===== dv/second_order_consensus_step_core_tb.sv =====
// Self-checking testbench for second_order_consensus_step_core: loads agents,
// steps the swarm under several gain and leader settings and checks every agent result.
// Depends on rtl/socs_pkg.sv and rtl/second_order_consensus_step_core.sv.
module second_order_consensus_step_core_tb;
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        logic [2:0] agent;
        logic signed [31:0] px, py, vx, vy, ux, uy;
        logic last;
    } agent_report_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [2:0] cfg_index = '0;
    logic [63:0] cfg_data = '0;
    logic s_tvalid = 1'b0;
    logic s_tready;
    logic [159:0] s_tdata = '0;
    logic s_tuser = 1'b0;
    logic m_tvalid;
    logic m_tready = 1'b0;
    logic [199:0] m_tdata;
    logic m_tlast;

    logic [63:0] leaders, alphas, betas;
    logic follow_on;
    logic [2:0] follow_idx;
    logic signed [31:0] pos_x[8], pos_y[8], vel_x[8], vel_y[8], ctl_x[8], ctl_y[8];

    agent_report_t expected_reports[$];
    int mismatches = 0;
    int hold_requests = 0;
    int hold_served = 0;
    int hold_left = 0;

    second_order_consensus_step_core dut (.*);

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    function automatic logic signed [31:0] clamp32(logic signed [63:0] x);
        if (x > 64'sd2147483647) return 32'sh7fffffff;
        if (x < -64'sd2147483648) return 32'sh80000000;
        return x[31:0];
    endfunction

    function automatic logic signed [31:0] integrate(logic signed [31:0] old,
            logic [23:0] dt, logic signed [31:0] rate);
        logic signed [63:0] p;
        p = $signed({40'd0, dt}) * 64'(rate);
        return clamp32(64'(old) + ((p + 64'sd8388608) >>> 24));
    endfunction

    task automatic predict_item(logic cmd, logic [2:0] idx, logic signed [31:0] ix,
            logic signed [31:0] iy, logic signed [31:0] ivx, logic signed [31:0] ivy,
            logic [23:0] dt);
        logic signed [31:0] nx[8], ny[8];
        logic signed [63:0] sx, sy, al, be;
        logic signed [31:0] ox, oy;
        agent_report_t r;
        if (cmd == socs_pkg::CMD_LOAD) begin
            pos_x[idx] = ix; pos_y[idx] = iy; vel_x[idx] = ivx; vel_y[idx] = ivy;
            ctl_x[idx] = 0; ctl_y[idx] = 0;
            return;
        end
        for (int i = 0; i < 8; i++) begin
            al = 64'(alphas[8*i +: 8]);
            be = 64'(betas[8*i +: 8]);
            sx = 0; sy = 0;
            for (int j = 0; j < 8; j++) begin
                if (leaders[8*i+j]) begin
                    sx += al * (64'(pos_x[j]) - 64'(pos_x[i]))
                        + be * (64'(vel_x[j]) - 64'(vel_x[i]));
                    sy += al * (64'(pos_y[j]) - 64'(pos_y[i]))
                        + be * (64'(vel_y[j]) - 64'(vel_y[i]));
                end
            end
            if (follow_on && follow_idx == i) begin
                sx += al * (64'(ix) - 64'(pos_x[i])) - be * 64'(vel_x[i]);
                sy += al * (64'(iy) - 64'(pos_y[i])) - be * 64'(vel_y[i]);
            end
            nx[i] = clamp32((sx + 16) >>> 5);
            ny[i] = clamp32((sy + 16) >>> 5);
        end
        for (int i = 0; i < 8; i++) begin
            ox = vel_x[i]; oy = vel_y[i];
            vel_x[i] = integrate(ox, dt, ctl_x[i]);
            vel_y[i] = integrate(oy, dt, ctl_y[i]);
            pos_x[i] = integrate(pos_x[i], dt, ox);
            pos_y[i] = integrate(pos_y[i], dt, oy);
            ctl_x[i] = nx[i]; ctl_y[i] = ny[i];
            r.agent = i[2:0]; r.px = pos_x[i]; r.py = pos_y[i]; r.vx = vel_x[i];
            r.vy = vel_y[i]; r.ux = ctl_x[i]; r.uy = ctl_y[i]; r.last = (i == 7);
            expected_reports = {expected_reports, r};
        end
    endtask

    function automatic int gap_len();
        int k;
        k = $urandom_range(0, 99);
        if (k < 50) return 0;
        if (k < 90) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    task automatic send_item(logic cmd, logic [2:0] idx, logic signed [31:0] ix,
            logic signed [31:0] iy, logic signed [31:0] ivx, logic signed [31:0] ivy,
            logic [23:0] dt);
        int gap;
        gap = gap_len();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= cmd;
        s_tdata <= {5'd0, dt, ivy, ivx, iy, ix, idx};
        do @(posedge aclk); while (!s_tready);
        predict_item(cmd, idx, ix, iy, ivx, ivy, dt);
    endtask

    task automatic write_reg(logic [2:0] idx, logic [63:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do @(posedge aclk); while (!cfg_ready);
        case (idx)
            socs_pkg::CFG_LEADER: leaders = val;
            socs_pkg::CFG_ALPHA: alphas = val;
            socs_pkg::CFG_BETA: betas = val;
            socs_pkg::CFG_FOLLOW_EN: follow_on = val[0];
            socs_pkg::CFG_FOLLOW_AGENT: follow_idx = val[2:0];
            default: ;
        endcase
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        while (expected_reports.size() != 0) @(posedge aclk);
        repeat (20) @(posedge aclk);
    endtask

    task automatic configure(logic [63:0] l, logic [63:0] a, logic [63:0] b,
            logic fe, logic [2:0] fa);
        drain();
        write_reg(socs_pkg::CFG_LEADER, l);
        write_reg(socs_pkg::CFG_ALPHA, a);
        write_reg(socs_pkg::CFG_BETA, b);
        write_reg(socs_pkg::CFG_FOLLOW_EN, {63'd0, fe});
        write_reg(socs_pkg::CFG_FOLLOW_AGENT, {61'd0, fa});
        cfg_valid <= 1'b0;
    endtask

    function automatic logic signed [31:0] rand_val();
        case ($urandom_range(0, 5))
            0: return 32'sh7fffffff;
            1: return 32'sh80000000;
            2: return $signed($urandom_range(0, 32'h3ffff)) - 32'sh20000;
            default: return $urandom();
        endcase
    endfunction

    task automatic test_extremes();
        configure(64'hffff_ffff_ffff_ffff, 64'hffff_ffff_ffff_ffff,
                  64'hffff_ffff_ffff_ffff, 1'b1, 3'd7);
        send_item(socs_pkg::CMD_LOAD, 3'd0, 32'sh7fffffff, 32'sh80000000, 32'sh7fffffff,
                  32'sh80000000, 24'd0);
        send_item(socs_pkg::CMD_LOAD, 3'd7, 32'sh80000000, 32'sh7fffffff, 32'sh80000000,
                  32'sh7fffffff, 24'hffffff);
        send_item(socs_pkg::CMD_STEP, 3'd5, 32'sh7fffffff, 32'sh80000000, 0, 0,
                  24'hffffff);
        send_item(socs_pkg::CMD_STEP, 3'd2, 32'sh80000000, 32'sh7fffffff, 0, 0,
                  24'hffffff);
        send_item(socs_pkg::CMD_STEP, 3'd0, 0, 0, 32'shffffffff, 32'shffffffff, 24'd0);
        send_item(socs_pkg::CMD_STEP, 3'd0, 0, 0, 0, 0, 24'h000001);
    endtask

    task automatic test_leader_follow();
        configure(64'h0102_0408_1020_4080, 64'h2020_2020_2020_2020,
                  64'h1010_1010_1010_1010, 1'b1, 3'd3);
        for (int i = 0; i < 8; i++)
            send_item(socs_pkg::CMD_LOAD, i[2:0], rand_val(), rand_val(), rand_val(),
                      rand_val(), 24'd0);
        for (int i = 0; i < 4; i++)
            send_item(socs_pkg::CMD_STEP, 3'($urandom()), $urandom(), $urandom(),
                      $urandom(), $urandom(), 24'h010000);
    endtask

    task automatic test_backpressure();
        hold_requests++;
        for (int i = 0; i < 4; i++)
            send_item(socs_pkg::CMD_STEP, 3'd0, 32'sh10000, 32'sh20000, 0, 0, 24'h080000);
    endtask

    task automatic test_random(int count);
        for (int n = 0; n < count; n++) begin
            if (n % 40 == 0)
                configure({$urandom(), $urandom()}, {$urandom(), $urandom()},
                          {$urandom(), $urandom()}, 1'($urandom()), 3'($urandom()));
            if ($urandom_range(0, 2) == 0)
                send_item(socs_pkg::CMD_STEP, 3'($urandom()), rand_val(), rand_val(),
                          $urandom(), $urandom(),
                          $urandom_range(0, 3) == 0 ? 24'($urandom()) :
                          24'($urandom_range(0, 24'h3ffff)));
            else
                send_item(socs_pkg::CMD_LOAD, 3'($urandom()), rand_val(), rand_val(),
                          rand_val(), rand_val(), 24'($urandom()));
        end
        configure(64'd0, 64'd0, 64'd0, 1'b0, 3'd0);
        send_item(socs_pkg::CMD_STEP, 3'd0, 0, 0, 0, 0, 24'h800000);
    endtask

    always @(posedge aclk) begin
        if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            m_tready <= 1'b0;
        end else if (hold_served != hold_requests) begin
            hold_served <= hold_requests;
            hold_left <= 600;
            m_tready <= 1'b0;
        end else if (aresetn) begin
            m_tready <= ($urandom_range(0, 9) < 7) || ($urandom_range(0, 9) == 0);
        end
    end

    always @(posedge aclk) begin
        agent_report_t e;
        logic [2:0] a;
        if (aresetn && m_tvalid && m_tready) begin
            a = m_tdata[2:0];
            if (expected_reports.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected transfer for agent %0d", a);
            end else begin
                e = expected_reports.pop_front();
                if (a !== e.agent || m_tdata[34:3] !== e.px || m_tdata[66:35] !== e.py
                        || m_tdata[98:67] !== e.vx || m_tdata[130:99] !== e.vy
                        || m_tdata[162:131] !== e.ux || m_tdata[194:163] !== e.uy
                        || m_tlast !== e.last) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: exp a%0d p(%0d,%0d) v(%0d,%0d) u(%0d,%0d) l%0d",
                                 e.agent, e.px, e.py, e.vx, e.vy, e.ux, e.uy, e.last,
                                 " got a%0d p(%0d,%0d) v(%0d,%0d) u(%0d,%0d) l%0d",
                                 a, $signed(m_tdata[34:3]), $signed(m_tdata[66:35]),
                                 $signed(m_tdata[98:67]), $signed(m_tdata[130:99]),
                                 $signed(m_tdata[162:131]), $signed(m_tdata[194:163]),
                                 m_tlast);
                end
            end
        end
    end

    initial begin
        leaders = 0; alphas = 0; betas = 0; follow_on = 0; follow_idx = 0;
        for (int i = 0; i < 8; i++) begin
            pos_x[i] = 0; pos_y[i] = 0; vel_x[i] = 0; vel_y[i] = 0;
            ctl_x[i] = 0; ctl_y[i] = 0;
        end
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        test_extremes();
        test_leader_follow();
        test_backpressure();
        test_random(128);
        drain();
        if (mismatches == 0 && expected_reports.size() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

    initial begin
        #20ms;
        $display("== FAIL ==");
        $finish;
    end
endmodule

// ===== files.f =====
rtl/socs_pkg.sv
rtl/second_order_consensus_step_core.sv
rtl/socs_checker.sv
dv/second_order_consensus_step_core_tb.sv
